@@ rtl/sarc_pkg.sv @@
// shared types and constants for the switch allocator request counters
package sarc_pkg;

    localparam int PORTS_DEFAULT      = 5;
    localparam int COUNT_BITS_DEFAULT = 8;

    localparam int CMD_W         = 1;
    localparam int PORT_FIELD_W  = 3;
    localparam int COUNT_FIELD_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST = 1'b0,
        CMD_GRANT   = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                    command;
        logic [PORT_FIELD_W-1:0] src_port;
        logic [PORT_FIELD_W-1:0] dst_port;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_FIELD_W-1:0] pending_count;
        logic                     granted;
        logic [PORT_FIELD_W-1:0]  winner_port;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/sarc_ctrl.sv @@
// sequencer for accept, counter lookup and counter update of one beat
module sarc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sarc_pkg::dp_status_t   status,
    output sarc_pkg::ctrl_cmd_t    ctrl
);
    import sarc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.lookup  = 1'b0;
        ctrl.update  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                ctrl.lookup = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (status.out_free) begin
                    ctrl.update = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sarc_datapath.sv @@
// counter memory, nonzero flags, priority pick and result register
module sarc_datapath #(
    parameter int PORTS      = sarc_pkg::PORTS_DEFAULT,
    parameter int COUNT_BITS = sarc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sarc_pkg::ctrl_cmd_t   ctrl,
    output sarc_pkg::dp_status_t  status,
    input  sarc_pkg::in_item_t    s_item,
    output sarc_pkg::out_item_t   m_item,
    output logic                  m_valid,
    input  logic                  m_ready
);
    import sarc_pkg::*;

    localparam int DEPTH  = PORTS * PORTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PIDX_W = $clog2(PORTS);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [PIDX_W-1:0] row,
                                                  input logic [PIDX_W-1:0] col);
        return ADDR_W'(32'(row) * PORTS + 32'(col));
    endfunction

    logic [COUNT_BITS-1:0] mem [DEPTH];

    in_item_t              item_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [PIDX_W-1:0]     win_reg;
    logic                  hit_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [DEPTH-1:0]      nz_reg;
    out_item_t             m_item_reg;
    logic                  m_valid_reg;

    logic [ADDR_W-1:0]     addr_next;
    logic [PIDX_W-1:0]     win_next;
    logic                  hit_next;
    out_item_t             m_item_next;

    logic                  ip_ok;
    logic                  op_ok;
    logic [PIDX_W-1:0]     row;
    logic [PIDX_W-1:0]     col;
    logic                  found;
    logic [PIDX_W-1:0]     found_idx;

    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic [COUNT_BITS-1:0] dec;
    logic [COUNT_BITS-1:0] new_val;

    // lookup: range checks and fixed priority pick over the column
    always_comb begin
        ip_ok     = 32'(item_reg.src_port) < PORTS;
        op_ok     = 32'(item_reg.dst_port) < PORTS;
        row       = PIDX_W'(item_reg.src_port);
        col       = PIDX_W'(item_reg.dst_port);
        found     = 1'b0;
        found_idx = '0;
        if (op_ok) begin
            for (int i = PORTS - 1; i >= 0; i--) begin
                if (nz_reg[addr_of(PIDX_W'(i), col)]) begin
                    found     = 1'b1;
                    found_idx = PIDX_W'(i);
                end
            end
        end
        if (item_reg.command == CMD_REQUEST) begin
            hit_next  = ip_ok && op_ok;
            addr_next = addr_of(row, col);
            win_next  = '0;
        end else begin
            hit_next  = found;
            addr_next = addr_of(found_idx, col);
            win_next  = found_idx;
        end
    end

    // update: read-modify-write of the selected counter
    always_comb begin
        cur     = nz_reg[addr_reg] ? rd_data_reg : '0;
        inc     = (cur == '1) ? cur : cur + COUNT_BITS'(1);
        dec     = cur - COUNT_BITS'(1);
        new_val = (item_reg.command == CMD_REQUEST) ? inc : dec;

        m_item_next.pending_count = '0;
        m_item_next.granted       = 1'b0;
        m_item_next.winner_port   = '0;
        if (hit_reg) begin
            if (item_reg.command == CMD_REQUEST) begin
                m_item_next.pending_count = COUNT_FIELD_W'(inc);
            end else begin
                m_item_next.granted     = 1'b1;
                m_item_next.winner_port = PORT_FIELD_W'(win_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            item_reg <= s_item;
        end
        if (ctrl.lookup) begin
            hit_reg     <= hit_next;
            addr_reg    <= addr_next;
            win_reg     <= win_next;
            rd_data_reg <= mem[addr_next];
        end
        if (ctrl.update && hit_reg) begin
            mem[addr_reg] <= new_val;
        end
        if (ctrl.update) begin
            m_item_reg <= m_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nz_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.update && hit_reg) begin
                nz_reg[addr_reg] <= (new_val != '0);
            end
            if (ctrl.update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_item          = m_item_reg;
    assign m_valid         = m_valid_reg;

    // result register is never overwritten while a beat waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.update |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while pending");

    // a grant only decrements a counter that was nonzero
    a_grant_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.update && hit_reg && item_reg.command == CMD_GRANT) |-> nz_reg[addr_reg])
        else $error("grant taken from an empty counter");

    // an update always presents a result next cycle
    a_update_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.update |=> m_valid_reg)
        else $error("update produced no result");

    // a granted result carries no count
    a_grant_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item_reg.granted) |-> (m_item_reg.pending_count == '0))
        else $error("grant result with nonzero count");

endmodule

@@ rtl/switch_allocator_request_counters.sv @@
// top level of the switch allocator request counters
// each input beat passes the accept, lookup and update states; update waits for a free output register
// a new beat is taken only after the previous one has finished its update, set by the registered read of the
// counter memory followed by its read-modify-write in the update state
// a new beat is accepted while the previous result still waits in the output register
// reset clears all nonzero flags at once, so every counter reads zero; no clearing pass
module switch_allocator_request_counters #(
    parameter int PORTS      = sarc_pkg::PORTS_DEFAULT,
    parameter int COUNT_BITS = sarc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sarc_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sarc_pkg::out_item_t  m_item
);
    import sarc_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    sarc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    sarc_datapath #(
        .PORTS      (PORTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .status  (status),
        .s_item  (s_item),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule
